@@ src/yuv_tpg_pkg.sv @@
// Shared types and constants of the YUV 4:2:0 test pattern generator.
// No dependencies; every other file of the block imports this package.
package yuv_tpg_pkg;

  localparam int DIM_W     = 13;  // width of the frame size registers
  localparam int OUT_POS_W = 12;  // reported column and row width
  localparam int SAMPLE_W  = 8;
  localparam int FRAME_W   = 30;
  localparam int PLANE_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_W     = 32;  // dividend width of the shared divider

  localparam logic [PLANE_W-1:0] PLANE_Y  = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_CB = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_CR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int DEFAULT_DIM = 2;
  localparam int LUMA_BASE   = 16;
  localparam int LUMA_MOD    = 220;
  localparam int CHROMA_FULL = 255;
  localparam int CHROMA_MID  = 128;

  // The luma ramp value divided by 220 is its upper 30 bits divided by 55.
  // For any 30-bit n, n / 55 equals (n * LUMA_RECIP) >> LUMA_RECIP_SHIFT,
  // where LUMA_RECIP is 2^36 / 55 rounded up.
  localparam int               LUMA_RECIP_W     = 31;
  localparam int               LUMA_PROD_W      = 61;
  localparam int               LUMA_RECIP_SHIFT = 36;
  localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 31'd1249445032;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // a beat is accepted on the input channel
    logic step;      // one divider iteration
    logic load_out;  // copy the finished result into the output register
  } tpg_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic no_div;    // the sample is finished after a single step
  } tpg_sts_t;

endpackage

@@ src/yuv_tpg_ctrl.sv @@
// Controller of the test pattern generator: handshakes and divider sequencing.
// Depends on yuv_tpg_pkg for the command and status types.
module yuv_tpg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  yuv_tpg_pkg::tpg_sts_t sts,
  output yuv_tpg_pkg::tpg_cmd_t cmd
);
  import yuv_tpg_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  typedef enum logic [1:0] {S_IDLE, S_DIVIDE, S_HOLD} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.start    = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.no_div || cnt_r == CNT_W'(DIV_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_HOLD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register stays full while the far side stalls it.
  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a beat that is still stalled");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (in_stall && !cmd.load_out))
    else $error("input not blocked after an accepted beat");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIVIDE) |-> (cnt_r == '0))
    else $error("iteration count left nonzero outside the divide phase");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_HOLD))
    else $error("output became valid without a finished result");

endmodule

@@ src/yuv_tpg_datapath.sv @@
// Datapath of the test pattern generator: scan counters, frame size registers,
// the shared restoring divider and the output register. Depends on yuv_tpg_pkg.
module yuv_tpg_datapath #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [yuv_tpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yuv_tpg_pkg::DIM_W-1:0]       cfg_data,
  input  logic                                in_restart,
  input  yuv_tpg_pkg::tpg_cmd_t               cmd,
  output yuv_tpg_pkg::tpg_sts_t               sts,
  output logic [yuv_tpg_pkg::PLANE_W-1:0]     out_plane,
  output logic [yuv_tpg_pkg::OUT_POS_W-1:0]   out_column,
  output logic [yuv_tpg_pkg::OUT_POS_W-1:0]   out_row,
  output logic [yuv_tpg_pkg::SAMPLE_W-1:0]    out_sample,
  output logic                                out_frame_end,
  output logic [yuv_tpg_pkg::FRAME_W-1:0]     out_frame_number
);
  import yuv_tpg_pkg::*;

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int CMP_W = (POS_W > DIM_W) ? POS_W : DIM_W;

  // Configuration.
  logic [DIM_W-1:0]   width_r, height_r;

  // Scan state.
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  // Current beat.
  logic [PLANE_W-1:0] it_plane_r;
  logic [POS_W-1:0]   it_x_r, it_y_r;
  logic               it_fend_r, it_luma_r, it_flat_r;
  logic [FRAME_W-1:0] it_frame_r;

  // Divider.
  logic [DIV_W-1:0]   dvd_r;
  logic [DIM_W-1:0]   rem_r, dvs_r;
  logic [DIM_W:0]     trial;
  logic               fits;

  // Luma remainder by reciprocal multiplication.
  logic [LUMA_PROD_W-1:0] luma_prod;
  logic [SAMPLE_W-1:0]    luma_q_r;
  logic [SAMPLE_W-1:0]    luma_rem;

  // Start-of-beat logic.
  logic [PLANE_W-1:0] pl0, pl;
  logic [POS_W-1:0]   col0, row0;
  logic [FRAME_W-1:0] frm0;
  logic               dims_ok;
  logic [DIM_W-1:0]   we, he, cw, ch, pw, ph;
  logic [DIM_W:0]     w_sum, h_sum;
  logic [CMP_W-1:0]   x_c, y_c;
  logic [POS_W-1:0]   x, y;
  logic               last_col, last_row, fend;
  logic [DIV_W-1:0]   dvd_load;
  logic [DIM_W-1:0]   dvs_load;
  logic               flat;
  logic [SAMPLE_W-1:0] sample_val;

  always_comb begin
    pl0  = in_restart ? PLANE_Y : plane_r;
    col0 = in_restart ? '0 : col_r;
    row0 = in_restart ? '0 : row_r;
    frm0 = in_restart ? '0 : frame_r;

    // Sizes out of range fall back to a two by two frame.
    dims_ok = (width_r != '0) && (height_r != '0) &&
              (32'(width_r) <= 32'(MAX_DIM)) && (32'(height_r) <= 32'(MAX_DIM));
    we = dims_ok ? width_r  : DIM_W'(DEFAULT_DIM);
    he = dims_ok ? height_r : DIM_W'(DEFAULT_DIM);
    w_sum = {1'b0, we} + (DIM_W + 1)'(1);
    h_sum = {1'b0, he} + (DIM_W + 1)'(1);
    cw = w_sum[DIM_W:1];
    ch = h_sum[DIM_W:1];

    pl = (pl0 > PLANE_CR) ? PLANE_CR : pl0;
    pw = (pl == PLANE_Y) ? we : cw;
    ph = (pl == PLANE_Y) ? he : ch;

    // A position left beyond a shrunken plane is pulled back to its edge.
    x_c = (CMP_W'(col0) >= CMP_W'(pw)) ? CMP_W'(pw) - CMP_W'(1) : CMP_W'(col0);
    y_c = (CMP_W'(row0) >= CMP_W'(ph)) ? CMP_W'(ph) - CMP_W'(1) : CMP_W'(row0);
    x = POS_W'(x_c);
    y = POS_W'(y_c);

    last_col = (x_c == CMP_W'(pw) - CMP_W'(1));
    last_row = (y_c == CMP_W'(ph) - CMP_W'(1));
    fend     = (pl == PLANE_CR) && last_col && last_row;

    flat     = 1'b0;
    dvd_load = 32'(x) * 32'(CHROMA_FULL);
    dvs_load = cw - DIM_W'(1);
    case (pl)
      PLANE_Y: begin
        dvd_load = 32'(x) + 32'(y) + {frm0, 2'b00};
      end
      PLANE_CB: begin
        flat = (cw == DIM_W'(1));
      end
      default: begin
        dvd_load = 32'(y) * 32'(CHROMA_FULL);
        dvs_load = ch - DIM_W'(1);
        flat     = (ch == DIM_W'(1));
      end
    endcase

    plane_nxt = pl;
    col_nxt   = '0;
    row_nxt   = '0;
    frame_nxt = frm0;
    if (!last_col) begin
      col_nxt = x + POS_W'(1);
      row_nxt = y;
    end else if (!last_row) begin
      row_nxt = y + POS_W'(1);
    end else if (pl == PLANE_CR) begin
      plane_nxt = PLANE_Y;
      frame_nxt = frm0 + FRAME_W'(1);
    end else begin
      plane_nxt = pl + PLANE_W'(1);
    end
  end

  // One quotient bit per iteration; the quotient shifts into the dividend.
  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Only the low byte of the luma quotient matters, since the remainder
  // below 220 is recovered modulo 256.
  assign luma_prod = LUMA_PROD_W'(dvd_r[DIV_W-1:2]) * LUMA_PROD_W'(LUMA_RECIP);
  assign luma_rem  = dvd_r[SAMPLE_W-1:0] - SAMPLE_W'(luma_q_r * SAMPLE_W'(LUMA_MOD));

  assign sts.no_div = it_flat_r || it_luma_r;

  always_comb begin
    if (it_flat_r) begin
      sample_val = SAMPLE_W'(CHROMA_MID);
    end else if (it_luma_r) begin
      sample_val = luma_rem + SAMPLE_W'(LUMA_BASE);
    end else begin
      sample_val = SAMPLE_W'(dvd_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(DEFAULT_DIM);
      height_r <= DIM_W'(DEFAULT_DIM);
      plane_r  <= PLANE_Y;
      col_r    <= '0;
      row_r    <= '0;
      frame_r  <= '0;
    end else begin
      if (cfg_wr_en && cfg_index == REG_FRAME_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_wr_en && cfg_index == REG_FRAME_HEIGHT) begin
        height_r <= cfg_data;
      end
      if (cmd.start) begin
        plane_r <= plane_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        frame_r <= frame_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      it_plane_r <= pl;
      it_x_r     <= x;
      it_y_r     <= y;
      it_fend_r  <= fend;
      it_frame_r <= frm0;
      it_luma_r  <= (pl == PLANE_Y);
      it_flat_r  <= flat;
      dvd_r      <= dvd_load;
      dvs_r      <= dvs_load;
      rem_r      <= '0;
    end else if (cmd.step) begin
      if (it_luma_r) begin
        luma_q_r <= luma_prod[LUMA_RECIP_SHIFT +: SAMPLE_W];
      end else begin
        dvd_r <= {dvd_r[DIV_W-2:0], fits};
        rem_r <= fits ? DIM_W'(trial - {1'b0, dvs_r}) : DIM_W'(trial);
      end
    end
    if (cmd.load_out) begin
      out_plane        <= it_plane_r;
      out_column       <= OUT_POS_W'(it_x_r);
      out_row          <= OUT_POS_W'(it_y_r);
      out_sample       <= sample_val;
      out_frame_end    <= it_fend_r;
      out_frame_number <= it_frame_r;
    end
  end

endmodule

@@ src/yuv420_test_pattern_generator_core.sv @@
// Top level of the YUV 4:2:0 test pattern generator.
// Depends on yuv_tpg_pkg, yuv_tpg_ctrl and yuv_tpg_datapath.
//
// Each input beat yields one sample of an I420 frame: the luma plane in
// raster order, then Cb, then Cr, each chroma plane half the size rounded up.
// Luma is a diagonal ramp that shifts by four every frame, Cb ramps across
// and Cr ramps down. A beat with restart set begins again at frame zero.
// A chroma ramp sample runs through a restoring divider that produces one
// quotient bit per clock, one for each of the 32 dividend bits: the beat is
// accepted, runs through the divider iterations and is then loaded into the
// output register. A luma sample takes its remainder by 220 from a
// reciprocal multiplication in one step, and a Cb plane that is one sample
// wide or a Cr plane that is one sample tall gives a constant, so those
// beats pass a single divider step before the load. A stalled output holds
// the finished sample back from the load. No new beat is taken until the
// finished sample is loaded; the next beat can then be taken while the
// output stalls. Frame sizes outside 1 to MAX_DIM are treated as 2 by 2.
module yuv420_test_pattern_generator_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [yuv_tpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yuv_tpg_pkg::DIM_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [yuv_tpg_pkg::PLANE_W-1:0]     out_plane,
  output logic [yuv_tpg_pkg::OUT_POS_W-1:0]   out_column,
  output logic [yuv_tpg_pkg::OUT_POS_W-1:0]   out_row,
  output logic [yuv_tpg_pkg::SAMPLE_W-1:0]    out_sample,
  output logic                                out_frame_end,
  output logic [yuv_tpg_pkg::FRAME_W-1:0]     out_frame_number
);
  import yuv_tpg_pkg::*;

  tpg_cmd_t cmd;
  tpg_sts_t sts;

  yuv_tpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  yuv_tpg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_restart       (in_restart),
    .cmd              (cmd),
    .sts              (sts),
    .out_plane        (out_plane),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_sample       (out_sample),
    .out_frame_end    (out_frame_end),
    .out_frame_number (out_frame_number)
  );

endmodule
